FILE: hdl/ipe_pkg.sv
// Shared types, codes and helpers for the infix precedence evaluator.
// No dependencies; compiled first.
package ipe_pkg;

  localparam int MAX_NUMS_DEF = 16;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       is_num;
    logic       is_op;
    logic       last;
    logic [3:0] digit;
    logic [1:0] op;
  } ipe_tok_t;

  // magnitude of a Q16.16 word; the most negative value maps to 2^31
  function automatic logic [31:0] mag32(logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  // sign a magnitude and clamp to 32 bits; bit 32 of the result is the sat flag
  function automatic logic [32:0] sat_mag(logic [47:0] m, logic neg);
    logic [32:0] r;
    if (!neg) begin
      if (m > 48'h0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                        r = {1'b0, m[31:0]};
    end else begin
      if (m > 48'h0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else                        r = {1'b0, ~m[31:0] + 32'd1};
    end
    return r;
  endfunction

endpackage

FILE: hdl/ipe_ifs.sv
// Valid/ready channel interfaces for the character input and the result output.
// No dependencies.
interface ipe_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ipe_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: hdl/ipe_front.sv
// Front end: accepts characters and classifies them into tokens.
// Depends on ipe_pkg and ipe_char_if.
module ipe_front (
  ipe_char_if.sink          in_ch,
  input  logic              q_full,
  output logic              push,
  output ipe_pkg::ipe_tok_t tok
);
  import ipe_pkg::*;

  logic [7:0] c;
  assign c = in_ch.char_code;

  always_comb begin
    tok        = '0;
    tok.last   = in_ch.last;
    tok.digit  = 4'(c - CH_ZERO);
    tok.is_num = (c >= CH_ZERO) && (c <= CH_NINE);
    tok.is_op  = 1'b1;
    unique case (c)
      CH_PLUS:  tok.op = OP_ADD;
      CH_MINUS: tok.op = OP_SUB;
      CH_STAR:  tok.op = OP_MUL;
      CH_SLASH: tok.op = OP_DIV;
      default:  tok.is_op = 1'b0;
    endcase
  end

  assign in_ch.ready = !q_full;
  // ignored characters vanish here unless they close the expression
  assign push = in_ch.valid && !q_full && (tok.is_num || tok.is_op || tok.last);

endmodule

FILE: hdl/ipe_fifo.sv
// Short token queue between front and back.
// Depends on ipe_pkg.
module ipe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ipe_pkg::ipe_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output ipe_pkg::ipe_tok_t q_tok
);
  import ipe_pkg::*;

  ipe_tok_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, rp_r;
  logic [Q_AW:0]    cnt_r;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tok   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)          wp_r <= wp_r + 1'b1;
      if (pop && q_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop && q_valid);
    end
  end

endmodule

FILE: hdl/ipe_back.sv
// Back end: token stores and the sequential two-level precedence evaluator.
// Depends on ipe_pkg and ipe_res_if.
module ipe_back #(
  parameter int MAX_NUMS = ipe_pkg::MAX_NUMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ipe_pkg::ipe_tok_t q_tok,
  output logic              pop,
  ipe_res_if.source         out_ch
);
  import ipe_pkg::*;

  localparam int AW = (MAX_NUMS > 1) ? $clog2(MAX_NUMS) : 1;
  localparam int CW = $clog2(MAX_NUMS + 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_MULF = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DIVF = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [31:0] nmem [MAX_NUMS];
  logic [1:0]  omem [MAX_NUMS];

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] nc_r, nc_nxt, oc_r, oc_nxt, k_r, k_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   term_r, term_nxt, acc_r, acc_nxt;
  logic          have_r, have_nxt, sat_r, sat_nxt, neg_r, neg_nxt;
  logic [1:0]    addop_r, addop_nxt;
  logic [31:0]   num_q;
  logic [1:0]    op_q;
  logic [63:0]   prod_r, prod_nxt;
  logic [47:0]   dnd_r, dnd_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   dvs_r, dvs_nxt;
  logic [5:0]    dcnt_r, dcnt_nxt;
  logic [31:0]   res_val_r, res_val_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  logic          rd_en, num_we, op_we;
  logic [AW-1:0] rd_naddr, rd_oaddr;
  logic [CW:0]   next_k;
  logic          adv;
  logic [32:0]   sum33, rem_sh, sm;
  logic          rem_ge;
  logic [31:0]   commit_val;
  logic          commit_sat;

  always_ff @(posedge clk) begin
    if (num_we) nmem[nc_r[AW-1:0]] <= {12'd0, q_tok.digit, 16'd0};
    if (op_we)  omem[oc_r[AW-1:0]] <= q_tok.op;
    if (rd_en) begin
      num_q <= nmem[rd_naddr];
      op_q  <= omem[rd_oaddr];
    end
  end

  // fold the pending product term into the running sum
  always_comb begin
    if (addop_r == OP_SUB) sum33 = {acc_r[31], acc_r} - {term_r[31], term_r};
    else                   sum33 = {acc_r[31], acc_r} + {term_r[31], term_r};
    commit_sat = have_r && (sum33[32] != sum33[31]);
    if (!have_r)         commit_val = term_r;
    else if (commit_sat) commit_val = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                 commit_val = sum33[31:0];
  end

  assign rem_sh = {rem_r[31:0], dnd_r[47]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    state_nxt   = state_r;
    nc_nxt      = nc_r;
    oc_nxt      = oc_r;
    ovf_nxt     = ovf_r;
    k_nxt       = k_r;
    term_nxt    = term_r;
    acc_nxt     = acc_r;
    have_nxt    = have_r;
    sat_nxt     = sat_r;
    neg_nxt     = neg_r;
    addop_nxt   = addop_r;
    prod_nxt    = prod_r;
    dnd_nxt     = dnd_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    dcnt_nxt    = dcnt_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    rd_en       = 1'b0;
    rd_naddr    = '0;
    rd_oaddr    = '0;
    num_we      = 1'b0;
    op_we       = 1'b0;
    pop         = 1'b0;
    adv         = 1'b0;
    sm          = '0;
    next_k      = {1'b0, k_r} + 1'b1;

    unique case (state_r)
      S_LOAD: begin
        pop = 1'b1;
        if (q_valid) begin
          if (q_tok.is_num) begin
            if (nc_r < CW'(MAX_NUMS)) begin
              num_we = 1'b1;
              nc_nxt = nc_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (q_tok.is_op) begin
            if (oc_r < CW'(MAX_NUMS)) begin
              op_we  = 1'b1;
              oc_nxt = oc_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (q_tok.last) state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (ovf_r || ({1'b0, nc_r} < ({1'b0, oc_r} + 1'b1))) begin
          res_val_nxt = '0;
          res_st_nxt  = ST_BAD;
          state_nxt   = S_OUT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        term_nxt  = num_q;
        have_nxt  = 1'b0;
        sat_nxt   = 1'b0;
        addop_nxt = OP_ADD;
        k_nxt     = '0;
        if (oc_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_naddr  = AW'(1);
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        unique case (op_q) inside
          OP_ADD, OP_SUB: begin
            acc_nxt   = commit_val;
            have_nxt  = 1'b1;
            sat_nxt   = sat_r | commit_sat;
            addop_nxt = op_q;
            term_nxt  = num_q;
            adv       = 1'b1;
          end
          OP_MUL: begin
            prod_nxt  = mag32(term_r) * mag32(num_q);
            neg_nxt   = term_r[31] ^ num_q[31];
            state_nxt = S_MULF;
          end
          default: begin
            if (num_q == '0) begin
              res_val_nxt = '0;
              res_st_nxt  = ST_DIVZ;
              state_nxt   = S_OUT;
            end else begin
              dnd_nxt   = {mag32(term_r), 16'd0};
              rem_nxt   = '0;
              dvs_nxt   = mag32(num_q);
              dcnt_nxt  = '0;
              neg_nxt   = term_r[31] ^ num_q[31];
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MULF: begin
        sm       = sat_mag(prod_r[63:16], neg_r);
        term_nxt = sm[31:0];
        sat_nxt  = sat_r | sm[32];
        adv      = 1'b1;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt  = rem_ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        dnd_nxt  = {dnd_r[46:0], rem_ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'd47) state_nxt = S_DIVF;
      end
      S_DIVF: begin
        sm       = sat_mag(dnd_r, neg_r);
        term_nxt = sm[31:0];
        sat_nxt  = sat_r | sm[32];
        adv      = 1'b1;
      end
      S_FIN: begin
        res_val_nxt = commit_val;
        res_st_nxt  = (sat_r || commit_sat) ? ST_SAT : ST_OK;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          nc_nxt    = '0;
          oc_nxt    = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase

    // operator k done: fetch operator k+1 and number k+2, or finish
    if (adv) begin
      k_nxt = next_k[CW-1:0];
      if (next_k < {1'b0, oc_r}) begin
        rd_en     = 1'b1;
        rd_oaddr  = next_k[AW-1:0];
        rd_naddr  = AW'(next_k + 1'b1);
        state_nxt = S_STEP;
      end else begin
        state_nxt = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      nc_r    <= '0;
      oc_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nc_r    <= nc_nxt;
      oc_r    <= oc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    term_r    <= term_nxt;
    acc_r     <= acc_nxt;
    have_r    <= have_nxt;
    sat_r     <= sat_nxt;
    neg_r     <= neg_nxt;
    addop_r   <= addop_nxt;
    prod_r    <= prod_nxt;
    dnd_r     <= dnd_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    dcnt_r    <= dcnt_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign out_ch.valid  = (state_r == S_OUT);
  assign out_ch.value  = res_val_r;
  assign out_ch.status = res_st_r;

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (nc_r <= CW'(MAX_NUMS)) && (oc_r <= CW'(MAX_NUMS)))
    else $error("store count beyond depth");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_DIVZ || out_ch.status == ST_BAD)
      |-> out_ch.value == '0)
    else $error("error result with nonzero value");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != '0))
    else $error("divider started on zero divisor");

  a_cleared_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |=> (nc_r == '0) && (oc_r == '0) && !ovf_r)
    else $error("stores not emptied after result");

endmodule

FILE: hdl/infix_precedence_evaluator.sv
// Top level: character front end, token queue and evaluating back end.
// Depends on ipe_pkg, ipe_ifs, ipe_front, ipe_fifo, ipe_back.
//
//  channel | dir | payload                          | handshake
//  in_ch   | in  | char_code[7:0], last             | valid/ready
//  out_ch  | out | value[31:0] Q16.16, status[1:0]  | valid/ready
//
// Characters are taken one per cycle while the 4-entry token queue has room.
// The back end stores one token per cycle while loading; after a last token
// it runs S_CHK and S_INIT, one step per operator (+ or - in S_STEP, * adds
// S_MULF, / adds the bit-serial divider S_DIV and S_DIVF), then S_FIN.
// Reset is synchronous, active low, and empties queue and stores at once.
// A stalled result holds the back end; the queue keeps taking characters until full.
module infix_precedence_evaluator #(
  parameter int MAX_NUMS = ipe_pkg::MAX_NUMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ipe_char_if.sink  in_ch,
  ipe_res_if.source out_ch
);
  import ipe_pkg::*;

  ipe_tok_t push_tok, q_tok;
  logic     push, full, pop, q_valid;

  ipe_front u_front (
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .tok    (push_tok)
  );

  ipe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  ipe_back #(.MAX_NUMS(MAX_NUMS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: dv/infix_precedence_evaluator_tb.sv
// Self-checking testbench for infix_precedence_evaluator: directed and random character streams, scoreboard.
// Depends on ipe_pkg, ipe_ifs and the RTL of the evaluator.
`timescale 1ns / 1ps
module infix_precedence_evaluator_tb;
  import ipe_pkg::*;

  localparam int NUM_DEPTH = MAX_NUMS_DEF;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } eval_word_t;

  logic clk;
  logic rst_n;

  ipe_char_if in_ch ();
  ipe_res_if  out_ch ();

  infix_precedence_evaluator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_word_t char_queue[$];
  eval_word_t expected_results[$];

  // expression state mirrored from the block's behavior
  logic signed [31:0] num_mem[NUM_DEPTH];
  logic [1:0]         op_mem[NUM_DEPTH];
  int                 num_cnt;
  int                 op_cnt;
  bit                 overflowed;

  int  error_count;
  int  results_seen;
  int  chars_sent;
  int  idle_cycles;
  bit  hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_q(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint abs_q(logic signed [31:0] a);
    longint x;
    x = a;
    return x < 0 ? -x : x;
  endfunction

  function automatic eval_word_t evaluate_expr();
    eval_word_t r;
    logic signed [31:0] nums[NUM_DEPTH];
    logic [1:0] ops[NUM_DEPTH];
    int nc, oc, i, j;
    bit sat;
    longint m;
    bit neg;
    logic signed [31:0] acc;
    r.value = '0;
    sat = 1'b0;
    nc = num_cnt;
    oc = op_cnt;
    if (overflowed || nc < oc + 1) begin
      r.status = ST_BAD;
      return r;
    end
    nums = num_mem;
    ops = op_mem;
    i = 0;
    while (i < oc) begin
      if (ops[i] == OP_MUL || ops[i] == OP_DIV) begin
        neg = (nums[i] < 0) != (nums[i+1] < 0);
        if (ops[i] == OP_MUL) begin
          m = (abs_q(nums[i]) * abs_q(nums[i+1])) >>> 16;
        end else begin
          if (nums[i+1] == 0) begin
            r.status = ST_DIVZ;
            return r;
          end
          m = (abs_q(nums[i]) <<< 16) / abs_q(nums[i+1]);
        end
        nums[i] = clamp_q(neg ? -m : m, sat);
        for (j = i + 1; j + 1 < nc; j++) nums[j] = nums[j+1];
        nc--;
        for (j = i; j + 1 < oc; j++) ops[j] = ops[j+1];
        oc--;
      end else begin
        i++;
      end
    end
    acc = nums[0];
    for (i = 0; i < oc; i++) begin
      if (ops[i] == OP_ADD) acc = clamp_q(longint'(acc) + longint'(nums[i+1]), sat);
      else acc = clamp_q(longint'(acc) - longint'(nums[i+1]), sat);
    end
    r.value = acc;
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic void absorb_char(char_word_t w);
    logic [1:0] code;
    bit is_op;
    is_op = 1'b1;
    code = OP_ADD;
    if (w.ch >= CH_ZERO && w.ch <= CH_NINE) begin
      if (num_cnt < NUM_DEPTH) begin
        num_mem[num_cnt] = {12'd0, w.ch[3:0], 16'd0};
        num_cnt++;
      end else begin
        overflowed = 1'b1;
      end
      is_op = 1'b0;
    end else if (w.ch == CH_PLUS) code = OP_ADD;
    else if (w.ch == CH_MINUS) code = OP_SUB;
    else if (w.ch == CH_STAR) code = OP_MUL;
    else if (w.ch == CH_SLASH) code = OP_DIV;
    else is_op = 1'b0;
    if (is_op) begin
      if (op_cnt < NUM_DEPTH) begin
        op_mem[op_cnt] = code;
        op_cnt++;
      end else begin
        overflowed = 1'b1;
      end
    end
    if (w.last) begin
      expected_results.push_back(evaluate_expr());
      num_cnt = 0;
      op_cnt = 0;
      overflowed = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.char_code <= '0;
      in_ch.last <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_char({in_ch.char_code, in_ch.last});
        chars_sent++;
        void'(char_queue.pop_front());
        send_gap = gap_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (char_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.char_code <= char_queue[0].ch;
        in_ch.last <= char_queue[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  int recv_gap;
  eval_word_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, value", out_ch.value, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.value !== want.value)
            report_mismatch("value", out_ch.value, want.value);
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
        end
        recv_gap = gap_len();
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles", WATCH_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_str(string s);
    for (int k = 0; k < s.len(); k++)
      char_queue.push_back({8'(s[k]), k == s.len() - 1});
  endtask

  function automatic logic [7:0] random_char(int noise_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < noise_pct) return 8'($urandom_range(0, 255));
    if (p < 50 + noise_pct / 2) return 8'(CH_ZERO + $urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic push_random_expr();
    int len, kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // well formed: digit (op digit)*, with an occasional ignored noise character
      len = $urandom_range(0, 10);
      char_queue.push_back({8'(CH_ZERO + $urandom_range(0, 9)), len == 0});
      for (int k = 0; k < len; k++) begin
        char_queue.push_back({random_char(0) inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}
          ? random_char(0) : CH_STAR, 1'b0});
        // replace with a real operator code
        char_queue[$].ch = (($urandom_range(0, 1)) ? CH_STAR : CH_PLUS);
        case ($urandom_range(0, 3))
          0: char_queue[$].ch = CH_PLUS;
          1: char_queue[$].ch = CH_MINUS;
          2: char_queue[$].ch = CH_STAR;
          default: char_queue[$].ch = CH_SLASH;
        endcase
        if ($urandom_range(0, 7) == 0)
          char_queue.push_back({8'($urandom_range(0, 255)) | 8'h80, 1'b0});
        char_queue.push_back({8'(CH_ZERO + $urandom_range(0, 9)), k == len - 1});
      end
    end else begin
      len = (kind == 9) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++)
        char_queue.push_back({random_char(30), k == len - 1});
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    num_cnt = 0;
    op_cnt = 0;
    overflowed = 1'b0;
    error_count = 0;
    results_seen = 0;
    chars_sent = 0;
    idle_cycles = 0;
    hold_off = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: precedence, divide by zero, saturation, bad forms, noise, store overflow
    push_str("9");
    push_str("1+2*3-4/8");
    push_str("5/0+1");
    push_str("9*9*9*9*9*9");
    push_str("0-9*9*9*9*9*9");
    push_str("1+");
    push_str("+");
    char_queue.push_back({8'hFF, 1'b1});
    push_str("9/7 ");
    push_str("99999999999999999+1");
    // long receiver hold-off while the sender keeps going
    for (int e = 0; e < 10; e++) push_str("2*3+4");
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
    wait (char_queue.size() == 0);
    for (int e = 0; e < 10; e++) push_str("8/3-1");
    for (int e = 0; e < 2; e++)
      for (int k = 0; k < 20; k++) char_queue.push_back({8'(CH_ZERO + k % 10), k == 19});
    push_str("1++++++++++++++++++1");

    while (chars_sent + char_queue.size() < 800) begin
      push_random_expr();
      if (char_queue.size() > 50) wait (char_queue.size() < 20);
    end
    wait (char_queue.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d characters, checked %0d results covering precedence, noise,",
             chars_sent, results_seen);
    $display("store overflow, divide by zero, saturation and long output stalls.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ipe_pkg.sv
hdl/ipe_ifs.sv
hdl/ipe_front.sv
hdl/ipe_fifo.sv
hdl/ipe_back.sv
hdl/infix_precedence_evaluator.sv
dv/infix_precedence_evaluator_tb.sv
